FILE: rtl/pal_pkg.sv
package pal_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_LOCATE = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  // Operation broadcast from the controller to every cell.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic is_get;
    logic is_locate;
  } cell_ctl_t;

  // Search wave that walks the chain one cell per cycle.
  typedef struct packed {
    logic                    valid;
    logic                    hit;
    logic signed [VAL_W-1:0] data;
    logic [POS_W-1:0]        pos;
  } scan_t;

endpackage

FILE: rtl/pal_cell.sv
module pal_cell #(
  parameter int CAPACITY = pal_pkg::DEFAULT_CAPACITY,
  parameter int K        = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  pal_pkg::cell_ctl_t                    ctl,
  input  logic [$clog2(CAPACITY)-1:0]           slot,
  input  logic signed [pal_pkg::VAL_W-1:0]      value,
  input  logic [$clog2(CAPACITY+1)-1:0]         count,
  input  logic signed [pal_pkg::VAL_W-1:0]      left_data,
  input  logic signed [pal_pkg::VAL_W-1:0]      right_data,
  output logic signed [pal_pkg::VAL_W-1:0]      data_o,
  input  pal_pkg::scan_t                        carry_i,
  output pal_pkg::scan_t                        carry_o
);
  import pal_pkg::*;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0]   MY_IDX = IDX_W'(K);
  localparam logic [COUNT_W-1:0] MY_CNT = COUNT_W'(K);
  localparam logic [POS_W-1:0]   MY_POS = POS_W'(K + 1);

  logic signed [VAL_W-1:0] data_r, data_nxt;
  scan_t                   carry_r, carry_nxt;
  logic                    match;

  // Insert: cells from the slot upward take their lower neighbor, the slot
  // itself takes the new value. Delete: cells from the slot upward take their
  // upper neighbor.
  always_comb begin
    data_nxt = data_r;
    if (ctl.shift_up) begin
      if (MY_IDX == slot) begin
        data_nxt = value;
      end else if (MY_IDX > slot) begin
        data_nxt = left_data;
      end
    end else if (ctl.shift_down) begin
      if (MY_IDX >= slot) begin
        data_nxt = right_data;
      end
    end
  end

  always_comb begin
    if (ctl.is_get) begin
      match = (MY_IDX == slot);
    end else begin
      match = ctl.is_locate && (MY_CNT < count) && (data_r == value);
    end
    carry_nxt = carry_i;
    if (carry_i.valid && !carry_i.hit && match) begin
      carry_nxt.hit  = 1'b1;
      carry_nxt.data = ctl.is_get ? data_r : '0;
      carry_nxt.pos  = ctl.is_get ? '0 : MY_POS;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r.valid <= 1'b0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  assign data_o  = data_r;
  assign carry_o = carry_r;

endmodule

FILE: rtl/positional_array_list.sv
// Ordered list of signed 32-bit values in CAPACITY cells, addressed by 1-based
// position. Issue a command with start while busy is low; exactly one result
// comes back on the out_ ports, marked by out_valid for a single cycle, and
// the receiver cannot stall it, so it must take every result beat as it comes.
// Insert, delete and every rejected command go through the execute state only,
// and their result is registered as they execute and leave it. Get at a
// valid position and locate send a search wave down the chain of cells, one
// cell per cycle, and their result is registered as the wave leaves the last
// cell, so busy stays high over the whole scan. Inserts and deletes move all
// later cells at once.
module positional_array_list #(
  parameter int CAPACITY = pal_pkg::DEFAULT_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_command,
  input  logic [pal_pkg::POS_W-1:0]         in_position,
  input  logic signed [pal_pkg::VAL_W-1:0]  in_value_in,
  output logic                              out_valid,
  output logic                              out_status,
  output logic signed [pal_pkg::VAL_W-1:0]  out_value_out,
  output logic [pal_pkg::POS_W-1:0]         out_found_position,
  output logic [pal_pkg::POS_W-1:0]         out_list_size
);
  import pal_pkg::*;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W   = ((COUNT_W > POS_W) ? COUNT_W : POS_W) + 1;

  state_t                  state_r, state_nxt;
  cmd_t                    cmd_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [VAL_W-1:0] val_r;
  logic [COUNT_W-1:0]      count_r, count_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [POS_W-1:0]        out_found_r, out_found_nxt;
  logic [POS_W-1:0]        out_size_r, out_size_nxt;

  logic [CMP_W-1:0]        pos_ext, cnt_ext;
  logic                    in_list, ins_ok, launch;
  logic [IDX_W-1:0]        slot;
  cell_ctl_t               ctl;

  logic signed [VAL_W-1:0] data_w [CAPACITY];
  scan_t                   carry_w [CAPACITY+1];

  assign pos_ext = CMP_W'(pos_r);
  assign cnt_ext = CMP_W'(count_r);
  assign in_list = (pos_r != '0) && (pos_ext <= cnt_ext);
  assign ins_ok  = (pos_r != '0) && (pos_ext <= cnt_ext + CMP_W'(1))
                   && (cnt_ext < CMP_W'(CAPACITY));
  assign slot    = IDX_W'(pos_ext - CMP_W'(1));

  assign ctl.shift_up   = (state_r == ST_EXEC) && (cmd_r == CMD_INSERT) && ins_ok;
  assign ctl.shift_down = (state_r == ST_EXEC) && (cmd_r == CMD_DELETE) && in_list;
  assign ctl.is_get     = (cmd_r == CMD_GET);
  assign ctl.is_locate  = (cmd_r == CMD_LOCATE);

  assign launch = (state_r == ST_EXEC)
                  && (((cmd_r == CMD_GET) && in_list) || (cmd_r == CMD_LOCATE));

  assign carry_w[0] = '{valid: launch, hit: 1'b0, data: '0, pos: '0};

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [VAL_W-1:0] left_d, right_d;
    if (k == 0) begin : g_first
      assign left_d = val_r;
    end else begin : g_mid_l
      assign left_d = data_w[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_d = data_w[k];
    end else begin : g_mid_r
      assign right_d = data_w[k+1];
    end

    pal_cell #(
      .CAPACITY (CAPACITY),
      .K        (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .slot       (slot),
      .value      (val_r),
      .count      (count_r),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (data_w[k]),
      .carry_i    (carry_w[k]),
      .carry_o    (carry_w[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= cmd_t'(in_command);
      pos_r <= in_position;
      val_r <= in_value_in;
    end
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_found_r  <= out_found_nxt;
    out_size_r   <= out_size_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_found_nxt  = out_found_r;
    out_size_nxt   = out_size_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_value_nxt = '0;
        out_found_nxt = '0;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (ins_ok) begin
              count_nxt = count_r + COUNT_W'(1);
            end
            out_valid_nxt  = 1'b1;
            out_status_nxt = !ins_ok;
            out_size_nxt   = POS_W'(count_nxt);
            state_nxt      = ST_IDLE;
          end
          CMD_DELETE: begin
            if (in_list) begin
              count_nxt = count_r - COUNT_W'(1);
            end
            out_valid_nxt  = 1'b1;
            out_status_nxt = !in_list;
            out_size_nxt   = POS_W'(count_nxt);
            state_nxt      = ST_IDLE;
          end
          CMD_GET: begin
            if (in_list) begin
              state_nxt = ST_SCAN;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = 1'b1;
              out_size_nxt   = POS_W'(count_r);
              state_nxt      = ST_IDLE;
            end
          end
          CMD_LOCATE: begin
            state_nxt = ST_SCAN;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        if (carry_w[CAPACITY].valid) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          out_value_nxt  = carry_w[CAPACITY].data;
          out_found_nxt  = carry_w[CAPACITY].pos;
          out_size_nxt   = POS_W'(count_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_value_out      = out_value_r;
  assign out_found_position = out_found_r;
  assign out_list_size      = out_size_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(CAPACITY))
    else $error("element count above capacity");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_EXEC) || ($past(state_r) == ST_SCAN))
    else $error("result beat without a command in progress");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift_up |=> count_r == $past(count_r) + COUNT_W'(1))
    else $error("insert did not grow the list by one");

  a_error_keeps_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> count_r == $past(count_r))
    else $error("rejected command changed the list size");

  a_wave_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    carry_w[CAPACITY].valid |-> state_r == ST_SCAN)
    else $error("search wave left the chain outside a scan");

endmodule
